// ----- hdl/fsvpc_pkg.sv -----
// shared types and constants for the feedback servo position controller
// used by the top level and the iterative divider; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fsvpc_pkg;

    // sequencer states of the top level
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DUTY,
        ST_SPAN,
        ST_ANGLE,
        ST_TRACK,
        ST_POS,
        ST_ERR,
        ST_MUL,
        ST_DRIVE,
        ST_DONE
    } t_state;

    // configuration register indexes
    localparam logic [1:0] CFG_DUTY_MIN   = 2'd0;
    localparam logic [1:0] CFG_DUTY_MAX   = 2'd1;
    localparam logic [1:0] CFG_GAIN       = 2'd2;
    localparam logic [1:0] CFG_STOP_VALUE = 2'd3;

    // register reset values
    localparam logic [14:0] DUTY_MIN_RST   = 15'd742;
    localparam logic [14:0] DUTY_MAX_RST   = 15'd24858;
    localparam logic [15:0] GAIN_RST       = 16'd256;
    localparam logic [7:0]  STOP_VALUE_RST = 8'd90;

    // divider geometry
    localparam int DIV_W   = 32;
    localparam int DSR_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // arithmetic constants, Q8 where an angle or a duty
    localparam logic [12:0] PERIOD_LO     = 13'd1000;
    localparam logic [12:0] PERIOD_HI     = 13'd1200;
    localparam logic [31:0] FULL_DUTY_Q8  = 32'd25600;
    localparam logic [31:0] TURN_Q8       = 32'd92160;
    localparam logic [16:0] ANGLE_MAX_Q8  = 17'd91904;
    localparam logic [18:0] HALF_TURN_Q8  = 19'd46080;
    localparam logic [16:0] LAST_RST_Q8   = 17'd46080;
    localparam logic [16:0] SPAN_BIAS     = 17'd256;
    localparam int          ERR_LIM_Q8    = 7680;
    localparam int          TURN_LIM      = 2047;
    localparam logic [7:0]  DRIVE_MAX     = 8'd180;

endpackage

`default_nettype wire

// ----- hdl/feedback_servo_position_control.sv -----
// Position controller for a continuous-rotation servo with PWM feedback.
// Input channel s_axis: one item per measured feedback period with the
// high and low times in microseconds and a signed multi-turn target angle.
// Output channel m_axis: one item per input item with the multi-turn
// position (Q8 degrees) and the servo drive; tuser flags a valid period.
// Configuration: write port i_cfg_we / i_cfg_idx / i_cfg_data, used idle.
// An item whose period lies in 1001..1199 us runs the duty division and then,
// when the duty is above the minimum and the span is positive, the angle
// division before it reaches the output register; otherwise the second
// division is skipped. An out-of-range period goes from the check straight
// to the result. s_axis_tready returns once the sequencer is back in idle.
// The shared 32-step divider is run once or twice per valid item (duty cycle,
// then angle, unless skipped). s_axis_tready is high only while the
// sequencer is idle, so one item is in work at a time.
// The result sits in an output register; a new item is accepted while it
// waits. When the receiver stalls, a finished result holds in the sequencer
// until the output register is free, and input is not accepted meanwhile.
// Reset (synchronous, active low) restores the register defaults, sets the
// last angle to 180 degrees and the turn count to zero, and empties the
// output register.
`timescale 1ns / 1ps
`default_nettype none

module feedback_servo_position_control (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,   // high_time[11:0], low_time[23:12], target_angle[44:24]
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // position[28:0], drive[36:29]
    output logic        m_axis_tuser,   // valid_res[0]
    // configuration writes
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [15:0] i_cfg_data
);

    fsvpc_pkg::t_state r_state, n_state;

    // configuration registers
    logic [14:0] r_dmin, r_dmax;
    logic [15:0] r_gain;
    logic [7:0]  r_stop;

    // tracking state
    logic [16:0]        r_last, n_last;
    logic signed [11:0] r_turns, n_turns;

    // item working registers
    logic [11:0]        r_hi, r_lo;
    logic signed [20:0] r_target;
    logic [14:0]        r_duty, n_duty;
    logic [16:0]        r_angle, n_angle;
    logic signed [28:0] r_pos, n_pos;
    logic signed [13:0] r_err, n_err;
    logic signed [30:0] r_prod, n_prod;
    logic               r_res_valid, n_res_valid;
    logic [7:0]         r_drive, n_drive;

    // output register
    logic               r_out_valid, n_out_valid;
    logic [39:0]        r_out_data;
    logic               r_out_user;

    // divider hookup
    logic        w_div_start;
    logic [31:0] w_div_dividend;
    logic [15:0] w_div_divisor;
    logic        w_div_done;
    logic [31:0] w_div_quot;

    // combinational helpers
    logic [12:0]        w_period;
    logic               w_period_ok;
    logic signed [16:0] w_num, w_span;
    logic signed [18:0] w_last_x, w_angle_x;
    logic               w_inc, w_dec;
    logic signed [29:0] w_err_full;
    logic signed [31:0] w_v;
    logic [7:0]         w_stop_sat;
    logic               w_accept;
    logic               w_out_free;

    assign w_accept   = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign w_period    = {1'b0, r_hi} + {1'b0, r_lo};
    assign w_period_ok = (w_period > fsvpc_pkg::PERIOD_LO) && (w_period < fsvpc_pkg::PERIOD_HI);
    assign w_stop_sat  = (r_stop > fsvpc_pkg::DRIVE_MAX) ? fsvpc_pkg::DRIVE_MAX : r_stop;

    // duty above minimum and span of the calibration
    assign w_num  = $signed({2'b0, r_duty}) - $signed({2'b0, r_dmin});
    assign w_span = $signed({2'b0, r_dmax}) - $signed({2'b0, r_dmin})
                  + $signed(fsvpc_pkg::SPAN_BIAS);

    // wrap detection against the previous angle
    assign w_last_x  = $signed({2'b0, r_last});
    assign w_angle_x = $signed({2'b0, r_angle});
    assign w_inc = (w_last_x > w_angle_x + $signed(fsvpc_pkg::HALF_TURN_Q8));
    assign w_dec = (w_last_x < w_angle_x - $signed(fsvpc_pkg::HALF_TURN_Q8));

    assign w_err_full = $signed({r_target[20], r_target, 8'b0}) - 30'(r_pos);
    assign w_v = $signed({8'b0, r_stop, 16'b0}) - 32'(r_prod);

    fsvpc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    // sequencer next state and datapath updates
    always_comb begin
        n_state        = r_state;
        n_last         = r_last;
        n_turns        = r_turns;
        n_duty         = r_duty;
        n_angle        = r_angle;
        n_pos          = r_pos;
        n_err          = r_err;
        n_prod         = r_prod;
        n_res_valid    = r_res_valid;
        n_drive        = r_drive;
        n_out_valid    = r_out_valid && !m_axis_tready;
        w_div_start    = 1'b0;
        w_div_dividend = 32'(r_hi) * fsvpc_pkg::FULL_DUTY_Q8;
        w_div_divisor  = 16'(w_period);
        s_axis_tready  = 1'b0;
        case (r_state)
            fsvpc_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (w_accept) begin
                    n_state = fsvpc_pkg::ST_CHECK;
                end
            end
            fsvpc_pkg::ST_CHECK: begin
                if (w_period_ok) begin
                    w_div_start = 1'b1;
                    n_state     = fsvpc_pkg::ST_DUTY;
                end else begin
                    n_res_valid = 1'b0;
                    n_pos       = '0;
                    n_drive     = w_stop_sat;
                    n_state     = fsvpc_pkg::ST_DONE;
                end
            end
            fsvpc_pkg::ST_DUTY: begin
                if (w_div_done) begin
                    n_duty  = w_div_quot[14:0];
                    n_state = fsvpc_pkg::ST_SPAN;
                end
            end
            fsvpc_pkg::ST_SPAN: begin
                // duty fits 15 bits, so a positive excess does too
                w_div_dividend = 32'(w_num[15:0]) * fsvpc_pkg::TURN_Q8;
                w_div_divisor  = w_span[15:0];
                if (w_num <= 0 || w_span <= 0) begin
                    n_angle = '0;
                    n_state = fsvpc_pkg::ST_TRACK;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = fsvpc_pkg::ST_ANGLE;
                end
            end
            fsvpc_pkg::ST_ANGLE: begin
                if (w_div_done) begin
                    n_angle = (w_div_quot > 32'(fsvpc_pkg::ANGLE_MAX_Q8)) ?
                              fsvpc_pkg::ANGLE_MAX_Q8 : w_div_quot[16:0];
                    n_state = fsvpc_pkg::ST_TRACK;
                end
            end
            fsvpc_pkg::ST_TRACK: begin
                if (w_inc && r_turns < 12'(fsvpc_pkg::TURN_LIM)) begin
                    n_turns = r_turns + 12'sd1;
                end else if (w_dec && r_turns > -12'(fsvpc_pkg::TURN_LIM)) begin
                    n_turns = r_turns - 12'sd1;
                end
                n_last  = r_angle;
                n_state = fsvpc_pkg::ST_POS;
            end
            fsvpc_pkg::ST_POS: begin
                n_pos   = $signed({12'b0, r_angle})
                        + 29'(r_turns) * $signed(29'(fsvpc_pkg::TURN_Q8));
                n_state = fsvpc_pkg::ST_ERR;
            end
            fsvpc_pkg::ST_ERR: begin
                if (w_err_full > 30'(fsvpc_pkg::ERR_LIM_Q8)) begin
                    n_err = 14'(fsvpc_pkg::ERR_LIM_Q8);
                end else if (w_err_full < -30'(fsvpc_pkg::ERR_LIM_Q8)) begin
                    n_err = -14'(fsvpc_pkg::ERR_LIM_Q8);
                end else begin
                    n_err = w_err_full[13:0];
                end
                n_state = fsvpc_pkg::ST_MUL;
            end
            fsvpc_pkg::ST_MUL: begin
                n_prod  = 31'(r_err) * $signed({15'b0, r_gain});
                n_state = fsvpc_pkg::ST_DRIVE;
            end
            fsvpc_pkg::ST_DRIVE: begin
                n_res_valid = 1'b1;
                if (w_v <= 0) begin
                    n_drive = '0;
                end else if (w_v[31:16] > 16'(fsvpc_pkg::DRIVE_MAX)) begin
                    n_drive = fsvpc_pkg::DRIVE_MAX;
                end else begin
                    n_drive = w_v[23:16];
                end
                n_state = fsvpc_pkg::ST_DONE;
            end
            fsvpc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = fsvpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fsvpc_pkg::ST_IDLE;
            end
        endcase
    end

    // state, tracking and output control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fsvpc_pkg::ST_IDLE;
            r_last      <= fsvpc_pkg::LAST_RST_Q8;
            r_turns     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_turns     <= n_turns;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmin <= fsvpc_pkg::DUTY_MIN_RST;
            r_dmax <= fsvpc_pkg::DUTY_MAX_RST;
            r_gain <= fsvpc_pkg::GAIN_RST;
            r_stop <= fsvpc_pkg::STOP_VALUE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fsvpc_pkg::CFG_DUTY_MIN:   r_dmin <= i_cfg_data[14:0];
                fsvpc_pkg::CFG_DUTY_MAX:   r_dmax <= i_cfg_data[14:0];
                fsvpc_pkg::CFG_GAIN:       r_gain <= i_cfg_data;
                fsvpc_pkg::CFG_STOP_VALUE: r_stop <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // item payload and working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hi     <= s_axis_tdata[11:0];
            r_lo     <= s_axis_tdata[23:12];
            r_target <= $signed(s_axis_tdata[44:24]);
        end
        r_duty      <= n_duty;
        r_angle     <= n_angle;
        r_pos       <= n_pos;
        r_err       <= n_err;
        r_prod      <= n_prod;
        r_res_valid <= n_res_valid;
        r_drive     <= n_drive;
        if (r_state == fsvpc_pkg::ST_DONE && w_out_free) begin
            r_out_data <= {3'b0, r_drive, r_pos};
            r_out_user <= r_res_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ----- hdl/fsvpc_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on fsvpc_pkg for its widths
`timescale 1ns / 1ps
`default_nettype none

module fsvpc_div (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_start,
    input  wire [fsvpc_pkg::DIV_W-1:0]        i_dividend,
    input  wire [fsvpc_pkg::DSR_W-1:0]        i_divisor,
    output logic                              o_done,
    output logic [fsvpc_pkg::DIV_W-1:0]       o_quot
);

    logic                              r_busy, n_busy;
    logic                              r_done, n_done;
    logic [fsvpc_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [fsvpc_pkg::DIV_W-1:0]       r_num, n_num;
    logic [fsvpc_pkg::DSR_W-1:0]       r_rem, n_rem;
    logic [fsvpc_pkg::DSR_W-1:0]       r_dsr;
    logic [fsvpc_pkg::DSR_W:0]         w_trial;
    logic [fsvpc_pkg::DSR_W:0]         w_diff;
    logic                              w_ge;

    // one restoring step: shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem, r_num[fsvpc_pkg::DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_dividend;
            n_rem  = '0;
        end else if (r_busy) begin
            n_num = {r_num[fsvpc_pkg::DIV_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[fsvpc_pkg::DSR_W-1:0] : w_trial[fsvpc_pkg::DSR_W-1:0];
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == fsvpc_pkg::DIV_CNT_W'(fsvpc_pkg::DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_rem <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

`default_nettype wire
